[sv/c_comment_stripper_defines.svh]
// assertion macros for the comment stripper checker
`ifndef C_COMMENT_STRIPPER_DEFINES_SVH
`define C_COMMENT_STRIPPER_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define CCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication that must hold on the next edge
`define CCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ccs_pkg.sv]
// types, mode codes and character constants of the comment stripper
package ccs_pkg;

	// recognised characters
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	// scan mode
	typedef enum logic [3:0] {
		M_CODE       = 4'd0,
		M_SLASH      = 4'd1,
		M_BLOCK      = 4'd2,
		M_BLOCK_STAR = 4'd3,
		M_LINE       = 4'd4,
		M_LINE_CONT  = 4'd5,
		M_CHAR       = 4'd6,
		M_CHAR_ESC   = 4'd7,
		M_STR        = 4'd8,
		M_STR_ESC    = 4'd9
	} mode_t;

	// one input transfer
	typedef struct packed {
		logic       text_start;
		logic [7:0] in_byte;
	} in_item_t;

	// one output transfer
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// bytes produced by one scanned byte
	typedef struct packed {
		logic [1:0] n;
		logic [7:0] a;
		logic [7:0] b;
	} scan_res_t;

endpackage

[sv/c_comment_stripper.sv]
// top level of the comment stripper
// path: an input byte is registered in the input stage and again in the result buffer before it is output
// throughput: one input byte per cycle; the held slash emits nothing, so its two-byte
// release fits the two-entry result buffer and input stalls only under output back-pressure
// reset: arst_n clears the input stage, the result buffer and sets the mode to normal code
module c_comment_stripper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_ready,
	input  ccs_pkg::in_item_t  text_item,
	output logic               strip_valid,
	input  logic               strip_ready,
	output ccs_pkg::out_item_t strip_item
);
	import ccs_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	scan_res_t res;

	assign text_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			item_s1 <= text_item;
		end
	end

	ccs_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.take    (advance),
		.res     (res)
	);

	ccs_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.res         (res),
		.advance     (advance),
		.strip_valid (strip_valid),
		.strip_ready (strip_ready),
		.strip_item  (strip_item)
	);

endmodule

[sv/ccs_scan.sv]
// scan mode register and per-byte decode
module ccs_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  ccs_pkg::in_item_t item_s1,
	input  logic             take,
	output ccs_pkg::scan_res_t res
);
	import ccs_pkg::*;

	mode_t      mode_q;
	mode_t      cur;
	mode_t      nxt;
	logic [7:0] c;

	assign c   = item_s1.in_byte;
	assign cur = item_s1.text_start ? M_CODE : mode_q;

	// next mode
	always_comb begin
		nxt = cur;
		case (cur)
			M_SLASH: begin
				if (c == CH_STAR) nxt = M_BLOCK;
				else if (c == CH_SLASH) nxt = M_LINE;
				else nxt = M_CODE;
			end
			M_BLOCK: begin
				if (c == CH_STAR) nxt = M_BLOCK_STAR;
			end
			M_BLOCK_STAR: begin
				if (c == CH_SLASH) nxt = M_CODE;
				else if (c != CH_STAR) nxt = M_BLOCK;
			end
			M_LINE: begin
				if (c == CH_BSLASH) nxt = M_LINE_CONT;
				else if (c == CH_CR || c == CH_LF) nxt = M_CODE;
			end
			M_LINE_CONT: begin
				if (c != CH_BSLASH && c != CH_CR && c != CH_LF) nxt = M_LINE;
			end
			M_CHAR: begin
				if (c == CH_BSLASH) nxt = M_CHAR_ESC;
				else if (c == CH_SQUOTE) nxt = M_CODE;
			end
			M_CHAR_ESC: nxt = M_CHAR;
			M_STR: begin
				if (c == CH_BSLASH) nxt = M_STR_ESC;
				else if (c == CH_DQUOTE) nxt = M_CODE;
			end
			M_STR_ESC: nxt = M_STR;
			default: begin
				// normal code, unused codes behave the same
				if (c == CH_SLASH) nxt = M_SLASH;
				else if (c == CH_SQUOTE) nxt = M_CHAR;
				else if (c == CH_DQUOTE) nxt = M_STR;
				else nxt = M_CODE;
			end
		endcase
	end

	// emitted bytes
	always_comb begin
		res.n = 2'd0;
		res.a = c;
		res.b = c;
		case (cur)
			M_SLASH: begin
				if (c != CH_STAR && c != CH_SLASH) begin
					res.n = 2'd2;
					res.a = CH_SLASH;
				end
			end
			M_BLOCK, M_BLOCK_STAR, M_LINE_CONT: res.n = 2'd0;
			M_LINE: begin
				if (c == CH_CR || c == CH_LF) res.n = 2'd1;
			end
			M_CHAR, M_CHAR_ESC, M_STR, M_STR_ESC: res.n = 2'd1;
			default: begin
				if (c != CH_SLASH) res.n = 2'd1;
			end
		endcase
	end

	// mode advances when the scanned byte leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_CODE;
		end else if (take) begin
			mode_q <= nxt;
		end
	end

endmodule

[sv/ccs_outq.sv]
// two-entry result buffer with room check for the input stage
module ccs_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  ccs_pkg::scan_res_t res,
	output logic               advance,
	output logic               strip_valid,
	input  logic               strip_ready,
	output ccs_pkg::out_item_t strip_item
);
	import ccs_pkg::*;

	out_item_t  slot0_q;
	out_item_t  slot1_q;
	out_item_t  nxt0;
	out_item_t  nxt1;
	out_item_t  e0;
	out_item_t  e1;
	logic [1:0] cnt_q;
	logic [1:0] cnt_nxt;
	logic [1:0] kept;
	logic [1:0] room;
	logic       pop;

	assign strip_valid = (cnt_q != 2'd0);
	assign strip_item  = slot0_q;
	assign pop         = strip_valid && strip_ready;
	assign kept        = cnt_q - {1'b0, pop};
	assign room        = 2'd2 - kept;
	assign advance     = valid_s1 && (res.n <= room);

	// entries to append
	assign e0 = '{out_byte: res.a, run_last: (res.n == 2'd1)};
	assign e1 = '{out_byte: res.b, run_last: 1'b1};

	// shift out the taken entry, then append
	always_comb begin
		nxt0 = pop ? slot1_q : slot0_q;
		nxt1 = slot1_q;
		cnt_nxt = kept;
		if (advance && res.n != 2'd0) begin
			cnt_nxt = kept + res.n;
			case (kept)
				2'd0: begin
					nxt0 = e0;
					if (res.n == 2'd2) nxt1 = e1;
				end
				2'd1: nxt1 = e0;
				default: nxt1 = slot1_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= nxt0;
		slot1_q <= nxt1;
	end

endmodule

[sv/ccs_checker.sv]
// port checker for the comment stripper, bound to the top level
`include "c_comment_stripper_defines.svh"

module ccs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               text_valid,
	input logic               text_ready,
	input logic               strip_valid,
	input logic               strip_ready,
	input ccs_pkg::out_item_t strip_item
);
	import ccs_pkg::*;

	logic pair_head;
	logic head_taken;
	logic all_idle;
	logic out_stall;

	// shorthand for the watched conditions
	assign pair_head  = strip_valid && !strip_item.run_last;
	assign head_taken = pair_head && strip_ready;
	assign all_idle   = !strip_valid && !text_valid;
	assign out_stall  = strip_valid && !strip_ready;

	// a first byte of a pair is always the held slash
	`CCS_ASSERT(a_pair_head_slash, pair_head |-> strip_item.out_byte == CH_SLASH, "bad pair head")
	// the second byte of a pair is ready right after the first transfer
	`CCS_ASSERT_NEXT(a_pair_tail_ready, head_taken, strip_valid, "pair tail missing")
	// input is taken again once the output drains
	`CCS_ASSERT_NEXT(a_ready_after_drain, all_idle, text_ready, "input stalled when idle")
	// a stalled output transfer keeps its payload
	`CCS_ASSERT_NEXT(a_out_hold, out_stall, strip_valid && $stable(strip_item), "output not held")

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.text_valid  (text_valid),
	.text_ready  (text_ready),
	.strip_valid (strip_valid),
	.strip_ready (strip_ready),
	.strip_item  (strip_item)
);
